### rtl/hermite_arc_length_defines.svh
// Assertion macros for the arc length block.
`ifndef HERMITE_ARC_LENGTH_DEFINES_SVH
`define HERMITE_ARC_LENGTH_DEFINES_SVH

`ifndef SYNTHESIS
`define HAL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define HAL_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define HAL_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define HAL_ASSERT_RST(lbl, clk_s, prop, msg)
`endif

`endif

### rtl/hal_pkg.sv
package hal_pkg;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int N_PTS = 5;
  localparam int FRAC_Q = 17;
  localparam int WGT_W = 17;
  localparam int LEN_W = 31;
  localparam int unsigned ALPHA_Q17 [N_PTS] = '{65536, 30247, 100825, 6149, 124923};
  localparam int unsigned WEIGHT_Q17 [N_PTS] = '{74566, 62735, 62735, 31054, 31054};
endpackage

### rtl/hal_seg_if.sv
interface hal_seg_if import hal_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF) ();
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;
  logic signed [COORD_WIDTH-1:0] tan_in_x;
  logic signed [COORD_WIDTH-1:0] tan_in_y;
  logic signed [COORD_WIDTH-1:0] tan_in_z;
  logic signed [COORD_WIDTH-1:0] tan_out_x;
  logic signed [COORD_WIDTH-1:0] tan_out_y;
  logic signed [COORD_WIDTH-1:0] tan_out_z;

  modport source (output valid, end_x, end_y, end_z, tan_in_x, tan_in_y, tan_in_z,
                  tan_out_x, tan_out_y, tan_out_z, input ready);
  modport sink (input valid, end_x, end_y, end_z, tan_in_x, tan_in_y, tan_in_z,
                tan_out_x, tan_out_y, tan_out_z, output ready);
endinterface

### rtl/hal_len_if.sv
interface hal_len_if import hal_pkg::*; ();
  logic valid;
  logic ready;
  logic [LEN_W-1:0] arc_length;

  modport source (output valid, arc_length, input ready);
  modport sink (input valid, arc_length, output ready);
endinterface

### rtl/hal_lane.sv
// One quadrature point: derivative of all three axes, squared and summed.
module hal_lane import hal_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ALPHA = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [COORD_WIDTH+3:0] c1 [3],
  input  logic signed [COORD_WIDTH+3:0] c2 [3],
  input  logic signed [COORD_WIDTH-1:0] t0 [3],
  output logic [2*COORD_WIDTH+11:0] sum_sq
);
  localparam int CXW = COORD_WIDTH + 4;
  localparam int M1W = CXW + 18;
  localparam int R1W = M1W - 16;
  localparam int PW  = CXW + 3;
  localparam int M2W = PW + 18;
  localparam int R2W = M2W - 16;
  localparam int DW  = PW + 3;
  localparam int MW  = COORD_WIDTH + 5;
  localparam logic signed [17:0] AL = 18'(ALPHA);

  logic signed [M1W-1:0] m1 [3];
  logic signed [CXW-1:0] c2_d [3];
  logic signed [COORD_WIDTH-1:0] t0_d1 [3], t0_d2 [3], t0_d3 [3];
  logic signed [PW-1:0] p [3];
  logic signed [M2W-1:0] m2 [3];
  logic [MW-1:0] mag [3];
  logic [2*MW-1:0] sq [3];

  logic [M1W-1:0] a1 [3];
  logic [M1W:0] s1 [3];
  logic [R1W-1:0] r1 [3];
  logic signed [PW-1:0] p_next [3];
  logic [M2W-1:0] a2 [3];
  logic [M2W:0] s2 [3];
  logic [R2W-1:0] r2 [3];
  logic signed [DW-1:0] d_next [3];
  logic [DW-1:0] dmag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a1[k] = m1[k][M1W-1] ? M1W'(-m1[k]) : M1W'(m1[k]);
      s1[k] = {1'b0, a1[k]} + (M1W+1)'(1 << (FRAC_Q-1));
      r1[k] = s1[k][M1W:FRAC_Q];
      p_next[k] = (m1[k][M1W-1] ? -$signed({1'b0, r1[k]}) : $signed({1'b0, r1[k]}))
                  + PW'(c2_d[k]);
      a2[k] = m2[k][M2W-1] ? M2W'(-m2[k]) : M2W'(m2[k]);
      s2[k] = {1'b0, a2[k]} + (M2W+1)'(1 << (FRAC_Q-1));
      r2[k] = s2[k][M2W:FRAC_Q];
      d_next[k] = (m2[k][M2W-1] ? -$signed({1'b0, r2[k]}) : $signed({1'b0, r2[k]}))
                  + DW'(t0_d3[k]);
      dmag[k] = d_next[k][DW-1] ? DW'(-d_next[k]) : DW'(d_next[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m1[k]    <= M1W'(c1[k] * AL);
        c2_d[k]  <= c2[k];
        t0_d1[k] <= t0[k];
        p[k]     <= p_next[k];
        t0_d2[k] <= t0_d1[k];
        m2[k]    <= M2W'(p[k] * AL);
        t0_d3[k] <= t0_d2[k];
        mag[k]   <= dmag[k][MW-1:0];
        sq[k]    <= mag[k] * mag[k];
      end
      sum_sq <= (2*MW+2)'(sq[0]) + (2*MW+2)'(sq[1]) + (2*MW+2)'(sq[2]);
    end
  end
endmodule

### rtl/hal_sqrt.sv
// Pipelined square root, one result bit per stage, rounded to nearest.
module hal_sqrt #(
  parameter int SW = 60
) (
  input  logic clk,
  input  logic en,
  input  logic [SW-1:0] radicand,
  output logic [SW/2:0] root_rnd
);
  localparam int RB = SW / 2;

  logic [SW-1:0] rem [RB+1];
  logic [RB-1:0] root [RB+1];

  assign rem[0]  = radicand;
  assign root[0] = '0;

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam int J = RB - 1 - k;
    logic [SW:0] trial;
    assign trial = ((SW+1)'(root[k]) << (J + 1)) + ((SW+1)'(1) << (2 * J));
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1]  <= rem[k] - trial[SW-1:0];
          root[k+1] <= root[k] | (RB'(1) << J);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_rnd <= (RB+1)'(root[RB]) + (RB+1)'(rem[RB] > SW'(root[RB]));
    end
  end
endmodule

### rtl/hermite_arc_length.sv
// Channel  Dir  Payload
// seg      in   end_x/y/z, tan_in_x/y/z, tan_out_x/y/z (signed Q.8)
// len      out  arc_length (unsigned Q.8, saturating)
//
// One segment per cycle unless the output stalls; stage order: S1, six lane stages,
// a square root of COORD_WIDTH+6 bit stages plus rounding, weight, sum, output.
// The root's bit-per-stage chain sets the depth.
// Synchronous reset clears the valid bits only.
// A stall at the output freezes the whole pipeline; seg.ready drops with it.
module hermite_arc_length import hal_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  hal_seg_if.sink   seg,
  hal_len_if.source len
);
  `include "hermite_arc_length_defines.svh"

  localparam int CXW = COORD_WIDTH + 4;
  localparam int MW  = COORD_WIDTH + 5;
  localparam int SW  = 2 * MW + 2;
  localparam int RB  = SW / 2;
  localparam int WPW = RB + 1 + WGT_W;
  localparam int ACW = WPW + 3;
  localparam int LAT = RB + 11;

  logic adv;
  logic [LAT-1:0] vld;

  logic signed [CXW-1:0] c1 [3], c2 [3];
  logic signed [COORD_WIDTH-1:0] t0 [3];
  logic signed [CXW-1:0] e_x [3], a_x [3], b_x [3];
  logic [SW-1:0] sum_sq [N_PTS];
  logic [RB:0] root [N_PTS];
  logic [WPW-1:0] wp [N_PTS];
  logic [ACW-1:0] acc;
  logic [ACW-1:0] acc_rnd;
  logic [LEN_W-1:0] arc_length;

  assign adv = !vld[LAT-1] || len.ready;
  assign seg.ready = adv;
  assign len.valid = vld[LAT-1];
  assign len.arc_length = arc_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], seg.valid};
    end
  end

  always_comb begin
    e_x[0] = CXW'(seg.end_x);
    e_x[1] = CXW'(seg.end_y);
    e_x[2] = CXW'(seg.end_z);
    a_x[0] = CXW'(seg.tan_in_x);
    a_x[1] = CXW'(seg.tan_in_y);
    a_x[2] = CXW'(seg.tan_in_z);
    b_x[0] = CXW'(seg.tan_out_x);
    b_x[1] = CXW'(seg.tan_out_y);
    b_x[2] = CXW'(seg.tan_out_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c1[k] <= CXW'(3) * (a_x[k] + b_x[k] - (e_x[k] <<< 1));
        c2[k] <= CXW'(6) * e_x[k] - (a_x[k] <<< 2) - (b_x[k] <<< 1);
      end
      t0[0] <= seg.tan_in_x;
      t0[1] <= seg.tan_in_y;
      t0[2] <= seg.tan_in_z;
    end
  end

  for (genvar i = 0; i < N_PTS; i++) begin : g_pt
    hal_lane #(.COORD_WIDTH(COORD_WIDTH), .ALPHA(ALPHA_Q17[i])) u_lane (
      .clk(clk), .en(adv), .c1(c1), .c2(c2), .t0(t0), .sum_sq(sum_sq[i])
    );
    hal_sqrt #(.SW(SW)) u_sqrt (
      .clk(clk), .en(adv), .radicand(sum_sq[i]), .root_rnd(root[i])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        wp[i] <= WPW'(root[i]) * WPW'(WEIGHT_Q17[i]);
      end
    end
  end

  assign acc_rnd = (acc + ACW'(1 << FRAC_Q)) >> (FRAC_Q + 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= ACW'(wp[0]) + ACW'(wp[1]) + ACW'(wp[2]) + ACW'(wp[3]) + ACW'(wp[4]);
      arc_length <= (acc_rnd > ACW'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : acc_rnd[LEN_W-1:0];
    end
  end

  `HAL_ASSERT(a_stall_hold, clk, rst, !adv |=> $stable(vld), "valid bits moved in a stall")
  `HAL_ASSERT(a_take, clk, rst, adv && seg.valid |=> vld[0], "accepted beat lost at entry")
  `HAL_ASSERT_RST(a_rst_clear, clk, rst |=> vld == '0, "valid bits survive reset")
endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hal_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int LIMIT = 3000;
  localparam int DRAIN = 2 * (CW + 21) + 20;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t seg_t [9];

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  logic [LEN_W-1:0] lengths_due [$];

  hal_seg_if #(.COORD_WIDTH(CW)) seg ();
  hal_len_if len ();

  hermite_arc_length #(.COORD_WIDTH(CW)) DUT (
    .clk(clk),
    .rst(rst),
    .seg(seg),
    .len(len)
  );

  always #5 clk = ~clk;

  function automatic longint round_q17(longint v);
    longint unsigned mag;
    longint unsigned r;
    mag = v < 0 ? -v : v;
    r = (mag + 64'd65536) >> FRAC_Q;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned root_nearest(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] b;
    logic [127:0] t;
    r = '0;
    b = 128'd1 << 126;
    while (b != 0) begin
      t = r + b;
      if (s >= t) begin
        s = s - t;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r[63:0];
  endfunction

  function automatic logic [LEN_W-1:0] arc_length_of(seg_t p);
    longint c1 [3];
    longint c2 [3];
    longint t0 [3];
    longint e, a, b, q, d, alpha;
    longint unsigned m, acc;
    logic [127:0] sq;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      e = p[k];
      a = p[3+k];
      b = p[6+k];
      t0[k] = a;
      c1[k] = 3 * (a + b - 2 * e);
      c2[k] = 6 * e - 4 * a - 2 * b;
    end
    for (int i = 0; i < N_PTS; i++) begin
      alpha = longint'(ALPHA_Q17[i]);
      sq = '0;
      for (int k = 0; k < 3; k++) begin
        q = round_q17(c1[k] * alpha) + c2[k];
        d = round_q17(q * alpha) + t0[k];
        m = d < 0 ? -d : d;
        sq = sq + 128'(m) * 128'(m);
      end
      acc = acc + root_nearest(sq) * longint'(WEIGHT_Q17[i]);
    end
    acc = (acc + (64'd1 << FRAC_Q)) >> (FRAC_Q + 1);
    return acc > 64'd2147483647 ? {LEN_W{1'b1}} : acc[LEN_W-1:0];
  endfunction

  initial begin
    seg.valid = 1'b0;
    {seg.end_x, seg.end_y, seg.end_z} = '0;
    {seg.tan_in_x, seg.tan_in_y, seg.tan_in_z} = '0;
    {seg.tan_out_x, seg.tan_out_y, seg.tan_out_z} = '0;
    len.ready = 1'b0;
  end

  // output back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      len.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      len.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      len.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && len.valid && len.ready) begin
      if (lengths_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: arc_length=%0d", len.arc_length);
      end else begin
        if (len.arc_length !== lengths_due[0]) begin
          errors++;
          if (errors <= 10)
            $display("arc_length mismatch: expected %0d, actual %0d",
                     lengths_due[0], len.arc_length);
        end
        void'(lengths_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((seg.valid && seg.ready) || (len.valid && len.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_seg(input seg_t p);
    logic hit;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      seg.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    seg.valid <= 1'b1;
    seg.end_x <= p[0];
    seg.end_y <= p[1];
    seg.end_z <= p[2];
    seg.tan_in_x <= p[3];
    seg.tan_in_y <= p[4];
    seg.tan_in_z <= p[5];
    seg.tan_out_x <= p[6];
    seg.tan_out_y <= p[7];
    seg.tan_out_z <= p[8];
    lengths_due.push_back(arc_length_of(p));
    do begin
      @(negedge clk);
      hit = seg.ready;
      @(posedge clk);
    end while (!hit);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 511) - 256);
      1: return coord_t'($urandom_range(0, 65535) - 32768);
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    seg_t p;
    p = '{default: '0};
    send_seg(p);
    p = '{default: CMAX};
    send_seg(p);
    p = '{default: CMIN};
    send_seg(p);
    p = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
    send_seg(p);
    p = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
    send_seg(p);
    p = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
    send_seg(p);
    p = '{256, 0, 0, 256, 0, 0, 256, 0, 0};
    send_seg(p);
    p = '{0, 0, 0, 0, 0, 1, 0, 0, 0};
    send_seg(p);
    p = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_seg(p);
    p = '{0, 0, 0, 0, 0, 0, 0, 0, -1};
    send_seg(p);
    p = '{1000, -2000, 3000, 0, 0, 0, 0, 0, 0};
    send_seg(p);
    p = '{0, 0, 0, CMAX, 0, 0, 0, CMIN, 0};
    send_seg(p);
  endtask

  task automatic test_random(input int count);
    seg_t p;
    for (int n = 0; n < count; n++) begin
      if (n % 400 == 200) quiet = 1'b1;
      if (n % 400 == 300) quiet = 1'b0;
      foreach (p[k]) p[k] = rand_coord();
      send_seg(p);
    end
  endtask

  task automatic test_steady(input int count);
    seg_t p;
    quiet = 1'b1;
    for (int n = 0; n < count; n++) begin
      foreach (p[k]) p[k] = coord_t'($urandom());
      send_seg(p);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1800);
    test_steady(200);
    seg.valid <= 1'b0;
    while (lengths_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
